### hdl/natr_pkg.sv
// Shared types and constants of the node availability timeline block.
package natr_pkg;

  // Operation codes carried in the input tuser.
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_PLACE = 2'd2;

  // Fixed field widths of the input and result transactions.
  localparam int TIME_W = 32;
  localparam int NODE_W = 16;
  localparam int SLOT_W = 7;
  localparam int COUNT_W = 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch the input transaction, clear result flags
    logic exec;        // perform clear or add on the latched item
    logic up_issue;    // read the next entry of the upward minimum scan
    logic up_eval;     // evaluate read data for the minimum scan
    logic set_fits;    // record that the job fits now
    logic down_init;   // start the downward suffix scan at the last entry
    logic down_issue;  // read the next entry of the downward scan
    logic down_eval;   // evaluate read data and subtract from the suffix
    logic load_out;    // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       used_zero;
    logic       up_done;
    logic       down_done;
    logic       fits;
  } sts_t;

endpackage

### hdl/natr_ctrl.sv
// Controller state machine of the node availability timeline block.
module natr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  natr_pkg::sts_t  sts,
  output natr_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_UP,
    S_DECIDE,
    S_DOWN,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

  always_comb begin
    cmd            = '0;
    state_nxt      = state_r;
    cmd.capture    = (state_r == S_IDLE) && in_tvalid;
    cmd.exec       = (state_r == S_EXEC);
    cmd.up_issue   = (state_r == S_UP) && !sts.up_done;
    cmd.up_eval    = (state_r == S_UP);
    cmd.set_fits   = (state_r == S_DECIDE) && sts.fits;
    cmd.down_init  = (state_r == S_DECIDE) && !sts.fits;
    cmd.down_issue = (state_r == S_DOWN) && !sts.down_done;
    cmd.down_eval  = (state_r == S_DOWN);
    cmd.load_out   = (state_r == S_FIN) && (!out_tvalid_r || out_tready);
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.op == natr_pkg::OP_PLACE && !sts.used_zero) state_nxt = S_UP;
        else state_nxt = S_FIN;
      end
      S_UP: begin
        if (sts.up_done) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.fits) state_nxt = S_FIN;
        else state_nxt = S_DOWN;
      end
      S_DOWN: begin
        if (sts.down_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (cmd.load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.load_out) out_tvalid_nxt = 1'b1;
    else if (out_tready) out_tvalid_nxt = 1'b0;
    else out_tvalid_nxt = out_tvalid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

endmodule

### hdl/natr_dp.sv
// Datapath of the node availability timeline block: timeline memories and scan logic.
module natr_dp #(
  parameter int SLOT_DEPTH = 128,
  parameter int COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  natr_pkg::cmd_t                cmd,
  output natr_pkg::sts_t                sts,
  input  logic                          cfg_wr,
  input  logic [natr_pkg::TIME_W-1:0]   cfg_data,
  input  logic [1:0]                    in_op,
  input  logic [natr_pkg::TIME_W-1:0]   in_event_time,
  input  logic [natr_pkg::NODE_W-1:0]   in_node_count,
  input  logic [natr_pkg::TIME_W-1:0]   in_job_limit,
  input  logic                          in_limit_unset,
  output logic                          out_fits_now,
  output logic                          out_reserved,
  output logic [natr_pkg::SLOT_W-1:0]   out_reserve_slot,
  output logic [natr_pkg::COUNT_W-1:0]  out_entry_count,
  output logic                          out_table_full
);

  localparam int TW = natr_pkg::TIME_W;
  localparam int NW = natr_pkg::NODE_W;
  localparam int AW = $clog2(SLOT_DEPTH);
  localparam int UW = $clog2(SLOT_DEPTH + 1);
  localparam int SW = ((COUNT_BITS > NW) ? COUNT_BITS : NW) + 1;
  localparam logic [SW-1:0] CNT_MAX = SW'((64'd1 << COUNT_BITS) - 64'd1);

  // Timeline memories.
  logic [TW-1:0]         time_mem [SLOT_DEPTH];
  logic [COUNT_BITS-1:0] idle_mem [SLOT_DEPTH];

  // Control state.
  logic [TW-1:0]         pmax_r;
  logic [UW-1:0]         used_r;
  logic [COUNT_BITS-1:0] total_r;
  logic [UW-1:0]         iss_r;
  logic                  rv_r;

  // Latched item and scan state.
  logic [1:0]            op_r;
  logic [TW-1:0]         evt_r;
  logic [NW-1:0]         cnt_r;
  logic [TW:0]           fini_r;
  logic [AW-1:0]         ra_r;
  logic [TW-1:0]         rd_time_r;
  logic [COUNT_BITS-1:0] rd_idle_r;
  logic [COUNT_BITS-1:0] min_r;
  logic                  stop_r;
  logic                  fits_r;
  logic                  resv_r;
  logic                  full_r;
  logic [AW-1:0]         start_r;

  // Combinational helpers.
  logic [TW:0]           fini_nxt;
  logic [UW-1:0]         iss_m1;
  logic [AW-1:0]         rd_addr;
  logic [SW-1:0]         cnt_x;
  logic [SW-1:0]         rd_idle_x;
  logic [SW-1:0]         min_x;
  logic [SW-1:0]         sum_x;
  logic [SW-1:0]         sat_x;
  logic [SW-1:0]         diff_x;
  logic                  do_add;
  logic                  add_ok;
  logic                  idle_ge;
  logic                  sub_wr;
  logic                  mem_wr;
  logic [AW-1:0]         wr_addr;
  logic [COUNT_BITS-1:0] wr_idle;
  logic [31:0]           used_ext;
  logic [31:0]           start_ext;

  always_comb begin
    fini_nxt  = {1'b0, in_event_time} + {1'b0, (in_limit_unset ? pmax_r : in_job_limit)};
    iss_m1    = iss_r - UW'(1);
    rd_addr   = cmd.down_issue ? iss_m1[AW-1:0] : iss_r[AW-1:0];
    cnt_x     = {{(SW-NW){1'b0}}, cnt_r};
    rd_idle_x = {{(SW-COUNT_BITS){1'b0}}, rd_idle_r};
    min_x     = {{(SW-COUNT_BITS){1'b0}}, min_r};
    sum_x     = {{(SW-COUNT_BITS){1'b0}}, total_r} + cnt_x;
    sat_x     = (sum_x > CNT_MAX) ? CNT_MAX : sum_x;
    diff_x    = rd_idle_x - cnt_x;
    idle_ge   = (rd_idle_x >= cnt_x);
    do_add    = cmd.exec && (op_r == natr_pkg::OP_ADD) && (cnt_r != '0);
    add_ok    = do_add && (used_r != UW'(SLOT_DEPTH));
    sub_wr    = cmd.down_eval && rv_r && !stop_r && idle_ge;
    mem_wr    = add_ok || sub_wr;
    wr_addr   = add_ok ? used_r[AW-1:0] : ra_r;
    wr_idle   = add_ok ? sat_x[COUNT_BITS-1:0] : diff_x[COUNT_BITS-1:0];
    used_ext  = 32'(used_r);
    start_ext = 32'(start_r);

    sts.op        = op_r;
    sts.used_zero = (used_r == '0);
    sts.up_done   = (iss_r == used_r);
    sts.down_done = (iss_r == '0);
    sts.fits      = (cnt_x <= min_x);
  end

  always_ff @(posedge clk) begin
    if (add_ok) time_mem[wr_addr] <= evt_r;
    if (mem_wr) idle_mem[wr_addr] <= wr_idle;
    rd_time_r <= time_mem[rd_addr];
    rd_idle_r <= idle_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pmax_r  <= '0;
      used_r  <= '0;
      total_r <= '0;
      iss_r   <= '0;
      rv_r    <= 1'b0;
    end else begin
      if (cfg_wr) pmax_r <= cfg_data;
      if (cmd.exec && op_r == natr_pkg::OP_CLEAR) begin
        used_r  <= '0;
        total_r <= '0;
      end else if (add_ok) begin
        used_r  <= used_r + UW'(1);
        total_r <= sat_x[COUNT_BITS-1:0];
      end
      if (cmd.capture) iss_r <= '0;
      else if (cmd.up_issue) iss_r <= iss_r + UW'(1);
      else if (cmd.down_init) iss_r <= used_r;
      else if (cmd.down_issue) iss_r <= iss_m1;
      rv_r <= cmd.up_issue || cmd.down_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_op;
      evt_r  <= in_event_time;
      cnt_r  <= in_node_count;
      fini_r <= fini_nxt;
      stop_r <= 1'b0;
      fits_r <= 1'b0;
      resv_r <= 1'b0;
      full_r <= 1'b0;
      start_r <= '0;
    end else begin
      if (do_add && !add_ok) full_r <= 1'b1;
      if (cmd.up_issue || cmd.down_issue) ra_r <= rd_addr;
      if (cmd.set_fits) fits_r <= 1'b1;
      if (cmd.down_init) stop_r <= 1'b0;
      if (cmd.up_eval && rv_r) begin
        // Entry 0 always counts; later entries count until one lies past the finish time.
        if (ra_r == '0) begin
          min_r <= rd_idle_r;
        end else if (!stop_r) begin
          if ({1'b0, rd_time_r} > fini_r) stop_r <= 1'b1;
          else if (rd_idle_r < min_r) min_r <= rd_idle_r;
        end
      end
      if (cmd.down_eval && rv_r && !stop_r) begin
        if (idle_ge) begin
          resv_r  <= 1'b1;
          start_r <= ra_r;
        end else begin
          stop_r <= 1'b1;
        end
      end
    end
    if (cmd.load_out) begin
      out_fits_now     <= fits_r;
      out_reserved     <= resv_r;
      out_reserve_slot <= start_ext[natr_pkg::SLOT_W-1:0];
      out_entry_count  <= used_ext[natr_pkg::COUNT_W-1:0];
      out_table_full   <= full_r;
    end
  end

endmodule

### hdl/node_availability_timeline_reserve.sv
// Top level of the node availability timeline block with backfill reservation.
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+----------------------------------------
//  in_     | slave     | in_tvalid / in_tready   | in_tdata (80 bits), in_tuser (3 bits)
//  out_    | master    | out_tvalid / out_tready | out_tdata (24 bits)
//  cfg_    | slave     | cfg_valid / cfg_ready   | cfg_data: partition_max_time (32 bits)
//
// Clear, add, an unused opcode and a place on an empty table pass from acceptance through the
// execute state to the finish state, and the next transaction is accepted once the result is loaded.
// A place on a non-empty table runs the minimum scan and, when the job does not fit now, the
// downward suffix scan: one timeline read per cycle for the minimum scan, then one per cycle
// for the downward suffix scan, each scan reading through registered memory outputs.
// Reset is synchronous and active low; it empties the table and zeroes the limit register.
// One item is worked on at a time; a finished result waits in the output register while
// the next transaction is accepted, and a stalled output holds the block before delivery.
module node_availability_timeline_reserve #(
  parameter int SLOT_DEPTH = 128,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input transaction.
  input  logic        in_tvalid,
  output logic        in_tready,
  // [31:0] event_time, [47:32] node_count, [79:48] job_limit
  input  logic [79:0] in_tdata,
  // [1:0] op, [2] limit_unset
  input  logic [2:0]  in_tuser,
  // Result transaction.
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] fits_now, [1] reserved, [8:2] reserve_slot, [16:9] entry_count,
  // [17] table_full, [23:18] zero
  output logic [23:0] out_tdata,
  // Configuration write of partition_max_time.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  natr_pkg::cmd_t cmd;
  natr_pkg::sts_t sts;

  logic                           fits_now;
  logic                           reserved;
  logic [natr_pkg::SLOT_W-1:0]    reserve_slot;
  logic [natr_pkg::COUNT_W-1:0]   entry_count;
  logic                           table_full;

  // The limit register can always take a write; the user must write it only while idle (not enforced here).
  assign cfg_ready = 1'b1;

  natr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  natr_dp #(
    .SLOT_DEPTH (SLOT_DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_wr           (cfg_valid && cfg_ready),
    .cfg_data         (cfg_data),
    .in_op            (in_tuser[1:0]),
    .in_event_time    (in_tdata[31:0]),
    .in_node_count    (in_tdata[47:32]),
    .in_job_limit     (in_tdata[79:48]),
    .in_limit_unset   (in_tuser[2]),
    .out_fits_now     (fits_now),
    .out_reserved     (reserved),
    .out_reserve_slot (reserve_slot),
    .out_entry_count  (entry_count),
    .out_table_full   (table_full)
  );

  assign out_tdata = {6'd0, table_full, entry_count, reserve_slot, reserved, fits_now};

  // A job that fits now never also takes a reservation.
  a_fit_excludes_resv: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("fits_now and reserved both set");

  // A dropped add reports neither a fit nor a reservation.
  a_full_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[17]) |-> (!out_tdata[0] && !out_tdata[1]))
    else $error("table_full set together with a place result");

  // Only one item is in work at a time: an accepted transaction closes the input.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an item is in work");

endmodule
